// ===== sv/mtf_pkg.sv =====
// ----------------------------------------------------------------------------
// mtf_pkg: shared constants and types for the move-to-front recency list
// Defaults for the list geometry, register map, opcodes and control states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mtf_pkg;

    localparam int DEPTH_DEFAULT    = 16;
    localparam int KEY_BITS_DEFAULT = 16;

    localparam int LIMIT_W  = 5;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    localparam int PDATA_W = 32;
    localparam int PADDR_W = 3;

    localparam logic REG_LIST_LIMIT = 1'b0;

    localparam logic OP_TOUCH = 1'b0;
    localparam logic OP_DUMP  = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } mtf_state_t;

endpackage

// ===== sv/mtf_stream_if.sv =====
// ----------------------------------------------------------------------------
// mtf_stream_if: request and response channels of the recency list
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mtf_req_if #(
    parameter int KEY_BITS = mtf_pkg::KEY_BITS_DEFAULT
);
    logic                valid;
    logic                ready;
    logic                operation;
    logic [KEY_BITS-1:0] item_key;

    modport source (output valid, output operation, output item_key, input ready);
    modport sink   (input valid, input operation, input item_key, output ready);
endinterface

interface mtf_rsp_if #(
    parameter int DEPTH    = mtf_pkg::DEPTH_DEFAULT,
    parameter int KEY_BITS = mtf_pkg::KEY_BITS_DEFAULT
);
    localparam int POS_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                valid;
    logic                ready;
    logic                hit;
    logic [POS_W-1:0]    position;
    logic [KEY_BITS-1:0] key_out;
    logic                key_valid;
    logic [CNT_W-1:0]    entry_count;
    logic                last;

    modport source (output valid, output hit, output position, output key_out,
                    output key_valid, output entry_count, output last, input ready);
    modport sink   (input valid, input hit, input position, input key_out,
                    input key_valid, input entry_count, input last, output ready);
endinterface

// ===== sv/mtf_cell.sv =====
// ----------------------------------------------------------------------------
// mtf_cell: one list slot
// Holds one key, compares it against the touched key, passes the first-hit
// flag, hit position and selected key down the row, and shifts on update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtf_cell #(
    parameter int DEPTH    = mtf_pkg::DEPTH_DEFAULT,
    parameter int KEY_BITS = mtf_pkg::KEY_BITS_DEFAULT,
    parameter int IDX      = 0,
    localparam int POS_W   = $clog2(DEPTH),
    localparam int CNT_W   = $clog2(DEPTH + 1)
) (
    input  logic                clk,
    input  logic                update,
    input  logic [KEY_BITS-1:0] key_in,
    input  logic [KEY_BITS-1:0] prev_key,
    input  logic [CNT_W-1:0]    cnt,
    input  logic [POS_W-1:0]    sel_idx,
    input  logic                hit_in,
    input  logic [POS_W-1:0]    pos_in,
    input  logic [KEY_BITS-1:0] sel_in,
    output logic [KEY_BITS-1:0] key_stored,
    output logic                hit_out,
    output logic [POS_W-1:0]    pos_out,
    output logic [KEY_BITS-1:0] sel_out
);

    localparam logic [CNT_W-1:0] IDX_CNT = CNT_W'(IDX);
    localparam logic [POS_W-1:0] IDX_POS = POS_W'(IDX);

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic                occupied;
    logic                match;

    assign occupied = IDX_CNT < cnt;
    assign match    = occupied && (key_reg == key_in);
    assign hit_out  = hit_in || match;
    assign pos_out  = pos_in | ((match && !hit_in) ? IDX_POS : '0);
    assign sel_out  = sel_in | ((sel_idx == IDX_POS) ? key_reg : '0);

    // slots at or before the hit shift back by one; later slots hold
    assign key_next   = hit_in ? key_reg : prev_key;
    assign key_stored = key_reg;

    always_ff @(posedge clk)
    begin
        if (update)
        begin
            key_reg <= key_next;
        end
    end

endmodule

// ===== sv/mtf_chain.sv =====
// ----------------------------------------------------------------------------
// mtf_chain: row of list slots
// Links DEPTH cells front to back; slot 0 takes the touched key on update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtf_chain #(
    parameter int DEPTH    = mtf_pkg::DEPTH_DEFAULT,
    parameter int KEY_BITS = mtf_pkg::KEY_BITS_DEFAULT,
    localparam int POS_W   = $clog2(DEPTH),
    localparam int CNT_W   = $clog2(DEPTH + 1)
) (
    input  logic                clk,
    input  logic                update,
    input  logic [KEY_BITS-1:0] key_in,
    input  logic [CNT_W-1:0]    cnt,
    input  logic [POS_W-1:0]    sel_idx,
    output logic                hit,
    output logic [POS_W-1:0]    hit_pos,
    output logic [KEY_BITS-1:0] sel_key
);

    logic [KEY_BITS-1:0] key_c [DEPTH+1];
    logic                hit_c [DEPTH+1];
    logic [POS_W-1:0]    pos_c [DEPTH+1];
    logic [KEY_BITS-1:0] sel_c [DEPTH+1];

    assign key_c[0] = key_in;
    assign hit_c[0] = 1'b0;
    assign pos_c[0] = '0;
    assign sel_c[0] = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        mtf_cell #(
            .DEPTH    (DEPTH),
            .KEY_BITS (KEY_BITS),
            .IDX      (i)
        ) u_cell (
            .clk        (clk),
            .update     (update),
            .key_in     (key_in),
            .prev_key   (key_c[i]),
            .cnt        (cnt),
            .sel_idx    (sel_idx),
            .hit_in     (hit_c[i]),
            .pos_in     (pos_c[i]),
            .sel_in     (sel_c[i]),
            .key_stored (key_c[i+1]),
            .hit_out    (hit_c[i+1]),
            .pos_out    (pos_c[i+1]),
            .sel_out    (sel_c[i+1])
        );
    end

    assign hit     = hit_c[DEPTH];
    assign hit_pos = pos_c[DEPTH];
    assign sel_key = sel_c[DEPTH];

endmodule

// ===== sv/move_to_front_recency_list_top.sv =====
// ----------------------------------------------------------------------------
// move_to_front_recency_list_top: move-to-front recency list
// Every result is loaded into the response register before it is offered.
// Touch: a single pass down the cell row. Dump: max(1, count) responses,
// one slot read through the row per cycle while the response is not stalled.
// Reset: count and output valid clear, list_limit returns to 16; no clear pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module move_to_front_recency_list_top #(
    parameter int DEPTH    = mtf_pkg::DEPTH_DEFAULT,
    parameter int KEY_BITS = mtf_pkg::KEY_BITS_DEFAULT,
    localparam int POS_W   = $clog2(DEPTH),
    localparam int CNT_W   = $clog2(DEPTH + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    mtf_req_if.sink                     req,
    mtf_rsp_if.source                   rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mtf_pkg::PADDR_W-1:0] paddr,
    input  logic [mtf_pkg::PDATA_W-1:0] pwdata,
    output logic [mtf_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int LW    = mtf_pkg::LIMIT_W;
    localparam int CMP_W = (CNT_W > LW) ? CNT_W : LW;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    mtf_pkg::mtf_state_t state_reg, state_next;

    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [LW-1:0]       limit_reg;
    logic [POS_W-1:0]    dump_idx_reg, dump_idx_next;

    logic                out_valid_reg, out_valid_next;
    logic                hit_reg, hit_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [KEY_BITS-1:0] key_out_reg, key_out_next;
    logic                key_valid_reg, key_valid_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                last_reg, last_next;
    logic                out_load;

    logic                out_free;
    logic                accept;
    logic                is_dump;
    logic                update;
    logic [POS_W-1:0]    sel_idx;
    logic                chain_hit;
    logic [POS_W-1:0]    chain_pos;
    logic [KEY_BITS-1:0] sel_key;
    logic [LW-1:0]       limit_eff;
    logic                full;
    logic                evict;
    logic                cfg_write;
    logic                cfg_sel;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_sel   = paddr[mtf_pkg::PADDR_W-1:2] == mtf_pkg::REG_LIST_LIMIT;
    assign cfg_write = psel && penable && pwrite && pready && cfg_sel;
    assign prdata    = cfg_sel ? mtf_pkg::PDATA_W'(limit_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= mtf_pkg::LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            limit_reg <= pwdata[LW-1:0];
        end
    end

    // request handshake and slot row
    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == mtf_pkg::ST_IDLE) && out_free;
    assign accept    = req.valid && req.ready;
    assign is_dump   = req.operation == mtf_pkg::OP_DUMP;
    assign update    = accept && !is_dump;

    assign limit_eff = (limit_reg == '0) ? LW'(1) : limit_reg;
    assign full      = (CMP_W'(cnt_reg) >= CMP_W'(limit_eff)) || (cnt_reg == FULL_CNT);
    assign evict     = !chain_hit && full;

    always_comb
    begin
        if (state_reg == mtf_pkg::ST_DUMP)
            sel_idx = dump_idx_reg;
        else if (is_dump)
            sel_idx = '0;
        else
            sel_idx = POS_W'(cnt_reg - CNT_W'(1));
    end

    mtf_chain #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_chain (
        .clk     (clk),
        .update  (update),
        .key_in  (req.item_key),
        .cnt     (cnt_reg),
        .sel_idx (sel_idx),
        .hit     (chain_hit),
        .hit_pos (chain_pos),
        .sel_key (sel_key)
    );

    // control
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        dump_idx_next  = dump_idx_reg;
        out_load       = 1'b0;
        hit_next       = 1'b0;
        pos_next       = '0;
        key_out_next   = '0;
        key_valid_next = 1'b0;
        count_next     = cnt_reg;
        last_next      = 1'b1;

        case (state_reg)
            mtf_pkg::ST_IDLE:
            begin
                if (accept && !is_dump)
                begin
                    out_load = 1'b1;
                    if (chain_hit)
                    begin
                        hit_next = 1'b1;
                        pos_next = chain_pos;
                    end
                    else
                    begin
                        if (!full)
                            cnt_next = cnt_reg + CNT_W'(1);
                        key_valid_next = evict;
                        key_out_next   = evict ? sel_key : '0;
                        count_next     = full ? cnt_reg : cnt_reg + CNT_W'(1);
                    end
                end
                else if (accept)
                begin
                    out_load = 1'b1;
                    if (cnt_reg != '0)
                    begin
                        key_out_next   = sel_key;
                        key_valid_next = 1'b1;
                        last_next      = cnt_reg == CNT_W'(1);
                        if (cnt_reg != CNT_W'(1))
                        begin
                            state_next    = mtf_pkg::ST_DUMP;
                            dump_idx_next = POS_W'(1);
                        end
                    end
                end
            end
            mtf_pkg::ST_DUMP:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    pos_next       = dump_idx_reg;
                    key_out_next   = sel_key;
                    key_valid_next = 1'b1;
                    last_next      = CNT_W'(dump_idx_reg) + CNT_W'(1) == cnt_reg;
                    dump_idx_next  = dump_idx_reg + POS_W'(1);
                    if (last_next)
                        state_next = mtf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mtf_pkg::ST_IDLE;
            end
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mtf_pkg::ST_IDLE;
            cnt_reg       <= '0;
            dump_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            dump_idx_reg  <= dump_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            hit_reg       <= hit_next;
            pos_reg       <= pos_next;
            key_out_reg   <= key_out_next;
            key_valid_reg <= key_valid_next;
            count_reg     <= count_next;
            last_reg      <= last_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.hit         = hit_reg;
    assign rsp.position    = pos_reg;
    assign rsp.key_out     = key_out_reg;
    assign rsp.key_valid   = key_valid_reg;
    assign rsp.entry_count = count_reg;
    assign rsp.last        = last_reg;

    // checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FULL_CNT)
        else $error("entry count above depth");

    a_miss_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (update && !chain_hit && !full) |=> cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("miss below limit did not add an entry");

    a_dump_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mtf_pkg::ST_DUMP) |-> !req.ready)
        else $error("request taken during dump");

    a_dump_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mtf_pkg::ST_DUMP) |-> CNT_W'(dump_idx_reg) < cnt_reg)
        else $error("dump index past list end");

    a_hit_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && hit_reg) |-> CNT_W'(pos_reg) < count_reg)
        else $error("hit position outside list");

endmodule
